FILE: hw/rtl/cdr_pkg.sv
package cdr_pkg;

	// field widths
	localparam int REQ_W   = 2;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 14;
	localparam int ADD_W   = 10;
	localparam int DOY_W   = 9;
	localparam int STAT_W  = 2;
	localparam int TGT_W   = 10;
	localparam int PROD_W  = 30;
	localparam int QUO_W   = 10;
	localparam int DIV_SH  = 20;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SET = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADV = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QRY = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SET_BAD = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ADV_BAD = 2'd2;

	// date constants
	localparam logic [YEAR_W-1:0]  BASE_YEAR  = 14'd1900;
	localparam logic [MONTH_W-1:0] FIRST_MON  = 4'd1;
	localparam logic [MONTH_W-1:0] LAST_MON   = 4'd12;
	localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
	localparam logic [DOY_W-1:0]   SHORT_YEAR = 9'd365;

	// reciprocal of 25 scaled by 2^20, exact for all 14-bit years
	localparam logic [15:0] DIV25_MUL = 16'd41944;
	localparam logic [YEAR_W-1:0] DIV25 = 14'd25;

	// datapath commands
	typedef struct packed {
		logic load;
		logic mul;
		logic chk;
		logic upd;
		logic out;
	} cdr_cmd_t;

	// days before the first of a month
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DOY_W-1:0] base;
		unique case (m)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + DOY_W'(leap && (m > 4'd2));
	endfunction

	// length of a month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                       len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
			default:                    len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: hw/rtl/cdr_req_if.sv
interface cdr_req_if;
	import cdr_pkg::*;

	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [MONTH_W-1:0] in_month;
	logic [DAY_W-1:0]   in_day;
	logic [YEAR_W-1:0]  in_year;
	logic signed [ADD_W-1:0] add_days;

	modport source (output valid, req_type, in_month, in_day, in_year, add_days,
		input ready);
	modport sink (input valid, req_type, in_month, in_day, in_year, add_days,
		output ready);
endinterface

FILE: hw/rtl/cdr_rsp_if.sv
interface cdr_rsp_if;
	import cdr_pkg::*;

	logic               valid;
	logic               ready;
	logic [MONTH_W-1:0] cur_month;
	logic [DAY_W-1:0]   cur_day;
	logic [YEAR_W-1:0]  cur_year;
	logic [DOY_W-1:0]   day_of_year;
	logic [DOY_W-1:0]   days_left;
	logic               leap_year;
	logic [STAT_W-1:0]  status;

	modport source (output valid, cur_month, cur_day, cur_year, day_of_year, days_left,
		leap_year, status, input ready);
	modport sink (input valid, cur_month, cur_day, cur_year, day_of_year, days_left,
		leap_year, status, output ready);
endinterface

FILE: hw/rtl/cdr_ctrl.sv
module cdr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output cdr_pkg::cdr_cmd_t cmd
);
	import cdr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic       out_v_q;
	logic       in_xfer;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_v_q;
	assign slot_free = !out_v_q || out_ready;

	// command decode
	always_comb begin
		cmd      = '0;
		cmd.load = in_xfer;
		cmd.mul  = (state_q == ST_MUL);
		cmd.chk  = (state_q == ST_CHK);
		cmd.upd  = (state_q == ST_UPD);
		cmd.out  = (state_q == ST_OUT) && slot_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_xfer) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_CHK;
				ST_CHK:  state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_OUT;
				ST_OUT:  if (slot_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_MUL)
		else $error("accepted request did not start processing");
	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q) == ST_OUT)
		else $error("result valid raised outside output step");
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && slot_free |=> (state_q == ST_IDLE) && out_v_q)
		else $error("output step did not deliver result");
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && !slot_free |=> state_q == ST_OUT)
		else $error("output step left while result pending");
`endif
endmodule

FILE: hw/rtl/cdr_dp.sv
module cdr_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cdr_pkg::cdr_cmd_t        cmd,
	input  logic [1:0]               req_type,
	input  logic [3:0]               in_month,
	input  logic [4:0]               in_day,
	input  logic [13:0]              in_year,
	input  logic signed [9:0]        add_days,
	output logic [3:0]               cur_month,
	output logic [4:0]               cur_day,
	output logic [13:0]              cur_year,
	output logic [8:0]               day_of_year,
	output logic [8:0]               days_left,
	output logic                     leap_year,
	output logic [1:0]               status
);
	import cdr_pkg::*;

	// captured request
	logic [REQ_W-1:0]   req_q;
	logic [MONTH_W-1:0] mon_in_q;
	logic [DAY_W-1:0]   day_in_q;
	logic [YEAR_W-1:0]  yr_in_q;
	logic [ADD_W-1:0]   add_q;

	// working registers
	logic [PROD_W-1:0]  prod_q;
	logic [TGT_W-1:0]   tgt_q;
	logic               in_leap_q;
	logic               adv_bad_q;
	logic [MONTH_W-1:0] adv_mon_q;
	logic [STAT_W-1:0]  stat_q;

	// stored date
	logic [MONTH_W-1:0] mon_q;
	logic [DAY_W-1:0]   day_q;
	logic [YEAR_W-1:0]  yr_q;
	logic               leap_q;

	logic [DOY_W-1:0]   doy_cur;
	logic [DOY_W-1:0]   ylen_cur;
	logic [QUO_W-1:0]   quo;
	logic [YEAR_W-1:0]  quo25;
	logic               in_leap;
	logic [MONTH_W-1:0] mcnt;
	logic               set_ok;

	assign doy_cur  = month_start(mon_q, leap_q) + DOY_W'(day_q);
	assign ylen_cur = SHORT_YEAR + DOY_W'(leap_q);

	// leap test of the requested year: divisible by 4, and by 16 if by 25
	assign quo     = prod_q[DIV_SH +: QUO_W];
	assign quo25   = YEAR_W'(quo) * DIV25;
	assign in_leap = (yr_in_q[1:0] == 2'd0) && ((yr_in_q != quo25) || (yr_in_q[3:0] == 4'd0));

	// month of the advance target: count month starts lying below it
	always_comb begin
		mcnt = FIRST_MON;
		for (int m = 2; m <= 12; m++) begin
			if (TGT_W'(month_start(MONTH_W'(m), leap_q)) < tgt_q) begin
				mcnt = mcnt + MONTH_W'(1);
			end
		end
	end

	// set validation
	assign set_ok = (yr_in_q >= BASE_YEAR) && (mon_in_q >= FIRST_MON) &&
		(mon_in_q <= LAST_MON) && (day_in_q >= FIRST_DAY) &&
		(day_in_q <= month_len(mon_in_q, in_leap_q));

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			mon_in_q <= in_month;
			day_in_q <= in_day;
			yr_in_q  <= in_year;
			add_q    <= add_days;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(yr_in_q) * PROD_W'(DIV25_MUL);
			tgt_q  <= TGT_W'(doy_cur) + TGT_W'(add_q[ADD_W-2:0]);
		end
		if (cmd.chk) begin
			in_leap_q <= in_leap;
			adv_bad_q <= add_q[ADD_W-1] || (tgt_q > TGT_W'(ylen_cur));
			adv_mon_q <= mcnt;
		end
	end

	// stored date update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mon_q  <= FIRST_MON;
			day_q  <= FIRST_DAY;
			yr_q   <= BASE_YEAR;
			leap_q <= 1'b0;
		end else if (cmd.upd) begin
			if (req_q == REQ_SET) begin
				if (set_ok) begin
					mon_q  <= mon_in_q;
					day_q  <= day_in_q;
					yr_q   <= yr_in_q;
					leap_q <= in_leap_q;
				end else begin
					mon_q  <= FIRST_MON;
					day_q  <= FIRST_DAY;
					yr_q   <= BASE_YEAR;
					leap_q <= 1'b0;
				end
			end else if ((req_q == REQ_ADV) && !adv_bad_q) begin
				mon_q <= adv_mon_q;
				day_q <= DAY_W'(tgt_q - TGT_W'(month_start(adv_mon_q, leap_q)));
			end
		end
	end

	// request status
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			priority if (req_q == REQ_SET) begin
				stat_q <= set_ok ? STAT_OK : STAT_SET_BAD;
			end else if (req_q == REQ_ADV) begin
				stat_q <= adv_bad_q ? STAT_ADV_BAD : STAT_OK;
			end else begin
				stat_q <= STAT_OK;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out) begin
			cur_month   <= mon_q;
			cur_day     <= day_q;
			cur_year    <= yr_q;
			day_of_year <= doy_cur;
			days_left   <= ylen_cur - doy_cur;
			leap_year   <= leap_q;
			status      <= stat_q;
		end
	end
endmodule

FILE: hw/rtl/calendar_date_register_unit.sv
// channel  dir  handshake      payload
// req      in   valid / ready  req_type, in_month, in_day, in_year, add_days
// rsp      out  valid / ready  cur_month, cur_day, cur_year, day_of_year,
//                              days_left, leap_year, status
//
// one request at a time: the result turns valid after the multiply, check, update
// and output steps, and the next request can transfer in that same cycle
// the steps are set by the controller sequence and the reciprocal multiply
// the result register holds a pending result; a new request is taken meanwhile,
// and the output step waits until rsp is free
// reset sets the stored date to 1-1-1900, no result pending
module calendar_date_register_unit (
	input  logic clk,
	input  logic arst_n,
	cdr_req_if.sink   req,
	cdr_rsp_if.source rsp
);
	import cdr_pkg::*;

	cdr_cmd_t cmd;

	// sequencer
	cdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// date datapath
	cdr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req.req_type),
		.in_month    (req.in_month),
		.in_day      (req.in_day),
		.in_year     (req.in_year),
		.add_days    (req.add_days),
		.cur_month   (rsp.cur_month),
		.cur_day     (rsp.cur_day),
		.cur_year    (rsp.cur_year),
		.day_of_year (rsp.day_of_year),
		.days_left   (rsp.days_left),
		.leap_year   (rsp.leap_year),
		.status      (rsp.status)
	);
endmodule

FILE: tb/sv/tb_calendar_date_register_unit.sv
module tb_calendar_date_register_unit;
	import cdr_pkg::*;

	// spare request code, behaves as a query
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic [REQ_W-1:0]   kind;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
		logic [ADD_W-1:0]   delta;
	} date_req_t;

	typedef struct {
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
		logic [DOY_W-1:0]   doy;
		logic [DOY_W-1:0]   left;
		logic               leap;
		logic [STAT_W-1:0]  status;
	} date_rsp_t;

	logic clk;
	logic arst_n;

	cdr_req_if req_if ();
	cdr_rsp_if rsp_if ();

	calendar_date_register_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// pending requests and expected dates
	date_req_t pending_reqs[$];
	date_rsp_t expected_dates[$];

	// shadow of the stored date
	logic [DAY_W-1:0]   cal_day;
	logic [MONTH_W-1:0] cal_month;
	logic [YEAR_W-1:0]  cal_year;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic        hold_go;
	int unsigned hold_left;
	int unsigned cycle_cnt;
	int unsigned fail_cnt;
	int unsigned set_cnt, adv_cnt, qry_cnt, set_rej, adv_rej, result_cnt;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input bit lp);
		if (m == 2)
			return lp ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// ordinal day of the shadow date
	function automatic int unsigned day_number();
		int unsigned n;
		n = cal_day;
		for (int unsigned m = 1; m < cal_month; m++)
			n += days_in_month(m, is_leap(cal_year));
		return n;
	endfunction

	// update the shadow date for one request and return the expected result
	function automatic date_rsp_t apply_request(input date_req_t r);
		date_rsp_t   res;
		int unsigned target;
		int unsigned ylen;
		int unsigned mon;
		bit          lp;
		res.status = STAT_OK;
		case (r.kind)
			REQ_SET: begin
				set_cnt++;
				if (r.year >= BASE_YEAR && r.month >= FIRST_MON && r.month <= LAST_MON &&
						r.day >= FIRST_DAY &&
						r.day <= days_in_month(r.month, is_leap(r.year))) begin
					cal_day   = r.day;
					cal_month = r.month;
					cal_year  = r.year;
				end else begin
					cal_day    = FIRST_DAY;
					cal_month  = FIRST_MON;
					cal_year   = BASE_YEAR;
					res.status = STAT_SET_BAD;
					set_rej++;
				end
			end
			REQ_ADV: begin
				adv_cnt++;
				lp     = is_leap(cal_year);
				target = day_number() + r.delta[ADD_W-2:0];
				if (r.delta[ADD_W-1] || target > (lp ? 366 : 365)) begin
					res.status = STAT_ADV_BAD;
					adv_rej++;
				end else begin
					// walk months until the ordinal fits
					mon = 1;
					while (mon < 12 && target > days_in_month(mon, lp)) begin
						target -= days_in_month(mon, lp);
						mon++;
					end
					cal_month = MONTH_W'(mon);
					cal_day   = DAY_W'(target);
				end
			end
			default: qry_cnt++;
		endcase
		lp         = is_leap(cal_year);
		ylen       = lp ? 366 : 365;
		res.month  = cal_month;
		res.day    = cal_day;
		res.year   = cal_year;
		res.doy    = DOY_W'(day_number());
		res.left   = DOY_W'(ylen - day_number());
		res.leap   = lp;
		return res;
	endfunction

	// random request, mostly well formed
	function automatic date_req_t random_request();
		date_req_t   r;
		int unsigned pick;
		int unsigned sel;
		r.kind  = REQ_QRY;
		r.month = MONTH_W'($urandom_range(15));
		r.day   = DAY_W'($urandom_range(31));
		r.year  = YEAR_W'($urandom_range(16383));
		r.delta = ADD_W'($urandom_range(1023));
		pick    = $urandom_range(99);
		if (pick < 30) begin
			r.kind = REQ_SET;
			if ($urandom_range(9) < 7) begin
				sel = $urandom_range(9);
				if (sel < 7)
					r.year = YEAR_W'($urandom_range(2500, 1900));
				else if (sel < 9)
					r.year = YEAR_W'(1900 + 100 * $urandom_range(5));
				else
					r.year = YEAR_W'($urandom_range(16383, 1900));
				r.month = MONTH_W'($urandom_range(12, 1));
				r.day   = DAY_W'($urandom_range(days_in_month(r.month, is_leap(r.year)), 1));
			end
		end else if (pick < 75) begin
			r.kind = REQ_ADV;
			sel    = $urandom_range(99);
			if (sel < 50)
				r.delta = ADD_W'($urandom_range(40));
			else if (sel < 65)
				r.delta = ADD_W'($urandom_range(366));
			else if (sel < 75)
				r.delta = ADD_W'($urandom_range(511, 367));
			else if (sel < 85)
				r.delta = ADD_W'(-int'($urandom_range(366, 1)));
		end else if (pick < 95) begin
			r.kind = REQ_QRY;
		end else begin
			r.kind = REQ_SPARE;
		end
		return r;
	endfunction

	task automatic queue_req(input logic [REQ_W-1:0] kind, input int unsigned month,
			input int unsigned day, input int unsigned year, input int delta);
		date_req_t r;
		r.kind  = kind;
		r.month = MONTH_W'(month);
		r.day   = DAY_W'(day);
		r.year  = YEAR_W'(year);
		r.delta = ADD_W'(delta);
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random(input int n);
		repeat (n) pending_reqs.push_back(random_request());
	endtask

	// wait until every queued request has been answered
	task automatic drain();
		while (pending_reqs.size() != 0 || req_if.valid || expected_dates.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		date_req_t seen;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				seen.kind  = req_if.req_type;
				seen.month = req_if.in_month;
				seen.day   = req_if.in_day;
				seen.year  = req_if.in_year;
				seen.delta = req_if.add_days;
				expected_dates.push_back(apply_request(seen));
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					seen = pending_reqs.pop_front();
					req_if.valid    <= 1'b1;
					req_if.req_type <= seen.kind;
					req_if.in_month <= seen.month;
					req_if.in_day   <= seen.day;
					req_if.in_year  <= seen.year;
					req_if.add_days <= seen.delta;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off counter
	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result receiver
	always @(posedge clk) begin
		if (arst_n)
			rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		date_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			result_cnt++;
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d-%0d-%0d status %0d",
					$time, rsp_if.cur_month, rsp_if.cur_day, rsp_if.cur_year, rsp_if.status);
				fail_cnt++;
			end else begin
				want = expected_dates.pop_front();
				check_field("cur_month", want.month, rsp_if.cur_month);
				check_field("cur_day", want.day, rsp_if.cur_day);
				check_field("cur_year", want.year, rsp_if.cur_year);
				check_field("day_of_year", want.doy, rsp_if.day_of_year);
				check_field("days_left", want.left, rsp_if.days_left);
				check_field("leap_year", want.leap, rsp_if.leap_year);
				check_field("status", want.status, rsp_if.status);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_dates.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		hold_go         = 1'b0;
		req_if.valid    = 1'b0;
		req_if.req_type = REQ_QRY;
		req_if.in_month = '0;
		req_if.in_day   = '0;
		req_if.in_year  = '0;
		req_if.add_days = '0;
		rsp_if.ready    = 1'b0;
		cal_day         = FIRST_DAY;
		cal_month       = FIRST_MON;
		cal_year        = BASE_YEAR;
		cycle_cnt       = 0;
		fail_cnt        = 0;
		set_cnt         = 0;
		adv_cnt         = 0;
		qry_cnt         = 0;
		set_rej         = 0;
		adv_rej         = 0;
		result_cnt      = 0;
		send_idle_pct   = 28;
		recv_idle_pct   = 55;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset date, spare code, leap rule, bounds, advances
		queue_req(REQ_QRY, 0, 0, 0, 0);
		queue_req(REQ_SPARE, 15, 31, 16383, 511);
		queue_req(REQ_SET, 12, 31, 2000, -1);
		queue_req(REQ_SET, 2, 29, 1900, 0);
		queue_req(REQ_SET, 2, 29, 2000, 0);
		queue_req(REQ_SET, 2, 29, 2100, 0);
		queue_req(REQ_SET, 2, 29, 2024, 0);
		queue_req(REQ_ADV, 0, 0, 0, 0);
		queue_req(REQ_ADV, 0, 0, 0, 306);
		queue_req(REQ_ADV, 0, 0, 0, 1);
		queue_req(REQ_SET, 0, 10, 2020, 0);
		queue_req(REQ_SET, 13, 1, 2020, 0);
		queue_req(REQ_SET, 15, 31, 16383, 0);
		queue_req(REQ_SET, 4, 31, 2021, 0);
		queue_req(REQ_SET, 4, 0, 2021, 0);
		queue_req(REQ_SET, 1, 31, 1899, 0);
		queue_req(REQ_SET, 12, 31, 16383, 0);
		queue_req(REQ_SET, 1, 1, 0, 0);
		queue_req(REQ_SET, 1, 1, 1900, 0);
		queue_req(REQ_ADV, 0, 0, 0, 364);
		queue_req(REQ_SET, 3, 1, 2023, 0);
		queue_req(REQ_ADV, 15, 31, 16383, -1);
		queue_req(REQ_ADV, 0, 0, 0, -512);
		queue_req(REQ_ADV, 0, 0, 0, 511);
		queue_req(REQ_ADV, 15, 31, 16383, 5);
		queue_req(REQ_QRY, 15, 31, 16383, -512);
		drain();

		// sender slow, receiver slower; one long receiver hold-off
		queue_random(80);
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		drain();
		queue_random(560);
		drain();

		// roles swapped
		@(negedge clk);
		send_idle_pct = 55;
		recv_idle_pct = 28;
		queue_random(320);
		drain();
		queue_random(320);
		drain();

		// full rate both sides
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(640);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_dates.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_dates.size());
			fail_cnt++;
		end
		$display("covered %0d results: %0d sets (%0d rejected), %0d advances (%0d rejected)",
			result_cnt, set_cnt, set_rej, adv_cnt, adv_rej);
		$display("plus %0d queries, under varied stalls and a %0d-cycle receiver hold-off",
			qry_cnt, LONG_HOLD);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
